// File: hw/rtl/r2q_pkg.sv
// Shared widths, branch codes and the sideband record for the matrix to quaternion pipeline.
package r2q_pkg;

  localparam int FRAC_BITS = 14;
  localparam int ENT_W     = 16;
  localparam int SUM_W     = ENT_W + 2;
  localparam int D_W       = ENT_W + 1;
  localparam int RAD_W     = 2 * ENT_W;
  localparam int ROOT_W    = RAD_W / 2;
  localparam int REM_W     = ROOT_W + 4;
  localparam int NUM_W     = RAD_W;
  localparam int DEN_W     = ROOT_W + 1;
  localparam int Q_W       = FRAC_BITS + 1;
  localparam int LANES     = 4;
  localparam logic [ENT_W-1:0] ONE = ENT_W'(1) << FRAC_BITS;

  typedef enum logic [1:0] {
    BR_TRACE = 2'd0,
    BR_Y     = 2'd1,
    BR_Z     = 2'd2,
    BR_X     = 2'd3
  } br_t;

  typedef struct packed {
    br_t                        br;
    logic                       bad;
    logic [LANES-1:0][D_W-1:0]  d;
  } side_t;

  function automatic logic [1:0] main_lane(input br_t br);
    logic [1:0] lane;
    case (br)
      BR_TRACE: lane = 2'd0;
      BR_Y:     lane = 2'd2;
      BR_Z:     lane = 2'd3;
      BR_X:     lane = 2'd1;
      default:  lane = 2'd0;
    endcase
    return lane;
  endfunction

endpackage

// File: hw/rtl/r2q_front.sv
// Trace test, branch choice, root argument and off-diagonal combinations.
module r2q_front import r2q_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [8:0][ENT_W-1:0]        m,
  output logic                         out_valid,
  output logic signed [SUM_W-1:0]      arg,
  output side_t                        side
);

  logic [8:0][ENT_W-1:0] m1;
  br_t                   br1;
  logic                  v1;

  logic signed [SUM_W-1:0] e [9];
  logic signed [SUM_W-1:0] tr;
  br_t                     br_next;

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      e[k] = {{(SUM_W-ENT_W){m[k][ENT_W-1]}}, m[k]};
    end
    tr = e[0] + e[4] + e[8];
    if (!tr[SUM_W-1]) begin
      br_next = BR_TRACE;
    end else if (e[4] > e[0]) begin
      br_next = BR_Y;
    end else if (e[8] > e[4]) begin
      br_next = BR_Z;
    end else begin
      br_next = BR_X;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1  <= m;
      br1 <= br_next;
    end
  end

  logic signed [SUM_W-1:0] f [9];
  logic signed [SUM_W-1:0] one_s;
  logic signed [SUM_W-1:0] a_next;
  logic signed [SUM_W-1:0] dd [LANES];
  side_t                   side_next;

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      f[k] = {{(SUM_W-ENT_W){m1[k][ENT_W-1]}}, m1[k]};
    end
    one_s = {{(SUM_W-ENT_W){1'b0}}, ONE};
    for (int k = 0; k < LANES; k++) begin
      dd[k] = '0;
    end
    case (br1)
      BR_TRACE: begin
        a_next = f[0] + f[4] + f[8] + one_s;
        dd[1]  = f[7] - f[5];
        dd[2]  = f[2] - f[6];
        dd[3]  = f[3] - f[1];
      end
      BR_Y: begin
        a_next = f[4] - (f[8] + f[0]) + one_s;
        dd[0]  = f[2] - f[6];
        dd[1]  = f[1] + f[3];
        dd[3]  = f[5] + f[7];
      end
      BR_Z: begin
        a_next = f[8] - (f[0] + f[4]) + one_s;
        dd[0]  = f[3] - f[1];
        dd[1]  = f[6] + f[2];
        dd[2]  = f[5] + f[7];
      end
      default: begin
        a_next = f[0] - (f[4] + f[8]) + one_s;
        dd[0]  = f[7] - f[5];
        dd[2]  = f[1] + f[3];
        dd[3]  = f[6] + f[2];
      end
    endcase
    side_next.br  = br1;
    side_next.bad = a_next[SUM_W-1] || (a_next == '0);
    for (int k = 0; k < LANES; k++) begin
      side_next.d[k] = dd[k][D_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      arg  <= a_next;
      side <= side_next;
    end
  end

endmodule

// File: hw/rtl/r2q_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module r2q_sqrt import r2q_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic signed [SUM_W-1:0] arg,
  input  side_t                   in_side,
  output logic                    out_valid,
  output logic [ROOT_W-1:0]       root,
  output side_t                   out_side
);

  logic [RAD_W-1:0]  rad  [ROOT_W+1];
  logic [REM_W-1:0]  rem  [ROOT_W+1];
  logic [ROOT_W-1:0] rt   [ROOT_W+1];
  side_t             sd   [ROOT_W+1];
  logic              vld  [ROOT_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad[0] <= in_side.bad ? '0 :
                (RAD_W'(arg[SUM_W-2:0]) << FRAC_BITS);
      rem[0] <= '0;
      rt[0]  <= '0;
      sd[0]  <= in_side;
    end
  end

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    localparam int J = ROOT_W - 1 - k;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic [REM_W-1:0]  rem_next;
    logic [ROOT_W-1:0] rt_next;

    always_comb begin
      rem_sh = {rem[k][REM_W-3:0], rad[k][2*J+1 -: 2]};
      trial  = REM_W'({rt[k], 2'b01});
      if (rem_sh >= trial) begin
        rem_next = rem_sh - trial;
        rt_next  = {rt[k][ROOT_W-2:0], 1'b1};
      end else begin
        rem_next = rem_sh;
        rt_next  = {rt[k][ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad[k+1] <= rad[k];
        rem[k+1] <= rem_next;
        rt[k+1]  <= rt_next;
        sd[k+1]  <= sd[k];
      end
    end
  end

  assign out_valid = vld[ROOT_W];
  assign root      = rt[ROOT_W];
  assign out_side  = sd[ROOT_W];

endmodule

// File: hw/rtl/r2q_div.sv
// Pipelined rounded division of the off-diagonal terms by twice the root, with saturation.
module r2q_div import r2q_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [ROOT_W-1:0]            root,
  input  side_t                        in_side,
  output logic                         out_valid,
  output logic [LANES-1:0][ENT_W-1:0]  q,
  output br_t                          out_br,
  output logic                         out_bad
);

  logic [LANES-1:0][NUM_W-1:0] rem  [Q_W+1];
  logic [LANES-1:0][Q_W-1:0]   quo  [Q_W+1];
  logic [LANES-1:0]            neg  [Q_W+1];
  logic [LANES-1:0]            ovf  [Q_W+1];
  logic [DEN_W-1:0]            den  [Q_W+1];
  logic [ROOT_W-1:0]           rt   [Q_W+1];
  br_t                         br   [Q_W+1];
  logic                        bad  [Q_W+1];
  logic                        vld  [Q_W+1];

  logic [LANES-1:0][NUM_W-1:0] num_next;
  logic [LANES-1:0]            neg_next;
  logic [LANES-1:0]            ovf_next;
  logic [DEN_W-1:0]            den_next;
  logic [D_W-1:0]              mag;

  always_comb begin
    den_next = {root, 1'b0};
    mag      = '0;
    for (int k = 0; k < LANES; k++) begin
      neg_next[k] = in_side.d[k][D_W-1];
      mag         = neg_next[k] ? (D_W'(0) - in_side.d[k]) : in_side.d[k];
      num_next[k] = (NUM_W'(mag) << FRAC_BITS) + NUM_W'(root);
      ovf_next[k] = {1'b0, num_next[k]} >= ((NUM_W+1)'(den_next) << Q_W);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= num_next;
      quo[0] <= '0;
      neg[0] <= neg_next;
      ovf[0] <= ovf_next;
      den[0] <= den_next;
      rt[0]  <= root;
      br[0]  <= in_side.br;
      bad[0] <= in_side.bad;
    end
  end

  for (genvar s = 0; s < Q_W; s++) begin : g_stage
    localparam int I = Q_W - 1 - s;
    logic [NUM_W:0]              dsh;
    logic [LANES-1:0][NUM_W-1:0] rem_next;
    logic [LANES-1:0][Q_W-1:0]   quo_next;

    always_comb begin
      dsh = (NUM_W+1)'(den[s]) << I;
      for (int k = 0; k < LANES; k++) begin
        rem_next[k] = rem[s][k];
        quo_next[k] = quo[s][k];
        if ({1'b0, rem[s][k]} >= dsh) begin
          rem_next[k]    = rem[s][k] - dsh[NUM_W-1:0];
          quo_next[k][I] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1] <= rem_next;
        quo[s+1] <= quo_next;
        neg[s+1] <= neg[s];
        ovf[s+1] <= ovf[s];
        den[s+1] <= den[s];
        rt[s+1]  <= rt[s];
        br[s+1]  <= br[s];
        bad[s+1] <= bad[s];
      end
    end
  end

  logic [LANES-1:0][ENT_W-1:0] q_next;
  logic [ENT_W-1:0]            lmag;
  logic [ROOT_W:0]             main_raw;
  logic [ENT_W-1:0]            main_val;

  always_comb begin
    lmag     = '0;
    main_raw = ({1'b0, rt[Q_W]} + (ROOT_W+1)'(1)) >> 1;
    main_val = (main_raw > (ROOT_W+1)'(ONE)) ? ONE : main_raw[ENT_W-1:0];
    for (int k = 0; k < LANES; k++) begin
      if (ovf[Q_W][k] || (ENT_W'(quo[Q_W][k]) > ONE)) begin
        lmag = ONE;
      end else begin
        lmag = ENT_W'(quo[Q_W][k]);
      end
      q_next[k] = neg[Q_W][k] ? (ENT_W'(0) - lmag) : lmag;
    end
    q_next[main_lane(br[Q_W])] = main_val;
    if (bad[Q_W]) begin
      q_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[Q_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q       <= q_next;
      out_br  <= br[Q_W];
      out_bad <= bad[Q_W];
    end
  end

endmodule

// File: hw/rtl/rotation_matrix_to_quaternion_core.sv
// Top level of the rotation matrix to quaternion converter.
//
// An item on the slave stream carries the nine Q2.14 matrix entries; the master
// stream returns one item per input with the quaternion (w,x,y,z) in Q2.14, the
// selected branch and a flag that marks a root argument that was not positive.
// The pipeline has 36 register stages: two for the trace test and branch setup,
// seventeen for the square root, which yields one root bit per stage after an
// operand register, and seventeen for the division: an operand register, fifteen
// stages that yield one quotient bit each, and the saturation and output register.
// Throughput is one item per cycle while the receiver takes results.
// When the receiver holds tready low with a result waiting, the whole pipeline
// freezes and s_axis_tready drops in the same cycle; nothing is lost or repeated.
// Synchronous reset empties the pipeline; payload registers are not cleared.
module rotation_matrix_to_quaternion_core import r2q_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // m00, m01, m02, m10, m11, m12, m20, m21, m22, 16 bits each
  input  logic [143:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // qw, qx, qy, qz, 16 bits each
  output logic [63:0]  m_axis_tdata,
  // branch_taken [1:0], bad_input [2]
  output logic [2:0]   m_axis_tuser
);

  logic                        en;
  logic                        f_valid;
  logic signed [SUM_W-1:0]     f_arg;
  side_t                       f_side;
  logic                        s_valid;
  logic [ROOT_W-1:0]           s_root;
  side_t                       s_side;
  logic [LANES-1:0][ENT_W-1:0] q;
  br_t                         br;
  logic                        bad;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  r2q_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_axis_tvalid),
    .m         (s_axis_tdata),
    .out_valid (f_valid),
    .arg       (f_arg),
    .side      (f_side)
  );

  r2q_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .arg       (f_arg),
    .in_side   (f_side),
    .out_valid (s_valid),
    .root      (s_root),
    .out_side  (s_side)
  );

  r2q_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_valid),
    .root      (s_root),
    .in_side   (s_side),
    .out_valid (m_axis_tvalid),
    .q         (q),
    .out_br    (br),
    .out_bad   (bad)
  );

  assign m_axis_tdata = q;
  assign m_axis_tuser = {bad, br};

endmodule

// File: verif/rotation_matrix_to_quaternion_core_tb.sv
// Self-checking testbench for the rotation matrix to quaternion converter.
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion_core_tb import r2q_pkg::*; ();

  typedef struct packed {
    logic [15:0] qw, qx, qy, qz;
    br_t         br;
    logic        bad;
  } quat_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [143:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [63:0]  m_axis_tdata;
  logic [2:0]   m_axis_tuser;

  logic [143:0] pending_mats[$];
  quat_t        expected_quats[$];
  int           mismatches = 0;
  bit           hold_sender = 1'b0;
  int           burst_left = 0;
  int           gap_left = 0;
  int           stall_phase = 0;

  rotation_matrix_to_quaternion_core uut (.*);

  always #5 clk = ~clk;

  function automatic longint sat_unit(input longint v);
    if (v > 16384) return 16384;
    if (v < -16384) return -16384;
    return v;
  endfunction

  function automatic longint half_over_root(input longint d, input longint r);
    longint mag, q;
    mag = (d < 0) ? -d : d;
    q = ((mag <<< FRAC_BITS) + r) / (2 * r);
    return sat_unit(d < 0 ? -q : q);
  endfunction

  function automatic quat_t convert_matrix(input logic [143:0] mat);
    longint m[9];
    longint tr, a, r, bit_v, v, mn;
    longint d[4];
    int     main_i;
    quat_t  q;
    for (int i = 0; i < 9; i++) m[i] = longint'($signed(mat[16*i +: 16]));
    tr = m[0] + m[4] + m[8];
    if (tr >= 0) begin
      q.br = BR_TRACE; main_i = 0; a = tr + 16384;
      d = '{0, m[7] - m[5], m[2] - m[6], m[3] - m[1]};
    end else if (m[4] > m[0]) begin
      q.br = BR_Y; main_i = 2; a = m[4] - (m[8] + m[0]) + 16384;
      d = '{m[2] - m[6], m[1] + m[3], 0, m[5] + m[7]};
    end else if (m[8] > m[4]) begin
      q.br = BR_Z; main_i = 3; a = m[8] - (m[0] + m[4]) + 16384;
      d = '{m[3] - m[1], m[6] + m[2], m[5] + m[7], 0};
    end else begin
      q.br = BR_X; main_i = 1; a = m[0] - (m[4] + m[8]) + 16384;
      d = '{m[7] - m[5], 0, m[1] + m[3], m[6] + m[2]};
    end
    q.bad = (a <= 0);
    {q.qw, q.qx, q.qy, q.qz} = '0;
    if (!q.bad) begin
      v = a <<< FRAC_BITS; r = 0; bit_v = 64'sd1 <<< 60;
      while (bit_v > v) bit_v = bit_v >>> 2;
      while (bit_v != 0) begin
        if (v >= r + bit_v) begin
          v = v - (r + bit_v); r = (r >>> 1) + bit_v;
        end else begin
          r = r >>> 1;
        end
        bit_v = bit_v >>> 2;
      end
      for (int k = 0; k < 4; k++) d[k] = half_over_root(d[k], r);
      mn = sat_unit((r + 1) >>> 1);
      d[main_i] = mn;
      q.qw = d[0][15:0]; q.qx = d[1][15:0]; q.qy = d[2][15:0]; q.qz = d[3][15:0];
    end
    return q;
  endfunction

  function automatic logic [143:0] pack_matrix(input int e[9]);
    logic [143:0] mat;
    for (int i = 0; i < 9; i++) mat[16*i +: 16] = e[i][15:0];
    return mat;
  endfunction

  function automatic int rand_entry(input bit wide);
    if (wide) return int'($signed(16'($urandom())));
    return $urandom_range(32768) - 16384;
  endfunction

  // Near-rotations built from a random unit quaternion exercise all branches.
  function automatic logic [143:0] random_rotation(input bit noisy);
    real w, x, y, z, n;
    real rm[9];
    int  e[9];
    w = $urandom_range(2000) / 1000.0 - 1.0;
    x = $urandom_range(2000) / 1000.0 - 1.0;
    y = $urandom_range(2000) / 1000.0 - 1.0;
    z = $urandom_range(2000) / 1000.0 - 1.0;
    n = $sqrt(w*w + x*x + y*y + z*z) + 1.0e-9;
    w = w / n; x = x / n; y = y / n; z = z / n;
    rm = '{1 - 2*(y*y + z*z), 2*(x*y - w*z), 2*(x*z + w*y),
           2*(x*y + w*z), 1 - 2*(x*x + z*z), 2*(y*z - w*x),
           2*(x*z - w*y), 2*(y*z + w*x), 1 - 2*(x*x + y*y)};
    for (int i = 0; i < 9; i++) begin
      e[i] = $rtoi(rm[i] * 16384.0);
      if (noisy) e[i] += $urandom_range(64) - 32;
    end
    return pack_matrix(e);
  endfunction

  always @(posedge clk) begin
    logic [143:0] mat;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (pending_mats.size() > 0 && !hold_sender && gap_left == 0) begin
        mat = pending_mats.pop_front();
        s_axis_tdata <= mat;
        expected_quats.push_back(convert_matrix(mat));
        s_axis_tvalid <= 1'b1;
        if (burst_left > 0) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(40);
          gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
        if (gap_left > 0) gap_left <= gap_left - 1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      stall_phase <= stall_phase + 1;
      case ((stall_phase / 300) % 3)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(3) != 0);
        default: m_axis_tready <= ((stall_phase % 7) < 3);
      endcase
    end
  end

  always @(posedge clk) begin
    quat_t got, exp_q;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[47:32],
             m_axis_tdata[63:48], br_t'(m_axis_tuser[1:0]), m_axis_tuser[2]};
      if (expected_quats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected output item %h", got);
      end else begin
        exp_q = expected_quats.pop_front();
        if (got !== exp_q) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"Mismatch: expected w=%h x=%h y=%h z=%h br=%0d bad=%b,",
                      " got w=%h x=%h y=%h z=%h br=%0d bad=%b"},
                     exp_q.qw, exp_q.qx, exp_q.qy, exp_q.qz, exp_q.br, exp_q.bad,
                     got.qw, got.qx, got.qy, got.qz, got.br, got.bad);
        end
      end
    end
  end

  initial begin
    int e[9];
    e = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384}; pending_mats.push_back(pack_matrix(e));
    e = '{16384, 0, 0, 0, -16384, 0, 0, 0, -16384}; pending_mats.push_back(pack_matrix(e));
    e = '{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384}; pending_mats.push_back(pack_matrix(e));
    e = '{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384}; pending_mats.push_back(pack_matrix(e));
    e = '{-16384, 0, 0, 0, -16384, 0, 0, 0, -16384}; pending_mats.push_back(pack_matrix(e));
    e = '{-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768};
    pending_mats.push_back(pack_matrix(e));
    e = '{32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767};
    pending_mats.push_back(pack_matrix(e));
    e = '{0, 32767, -32768, -32768, 0, 32767, 32767, -32768, 0};
    pending_mats.push_back(pack_matrix(e));
    e = '{-1, 0, 0, 0, -1, 0, 0, 0, 1}; pending_mats.push_back(pack_matrix(e));
    e = '{-100, 0, 0, 0, -100, 0, 0, 0, -100}; pending_mats.push_back(pack_matrix(e));
    e = '{-8192, 0, 0, 0, -8192, 0, 0, 0, -8192}; pending_mats.push_back(pack_matrix(e));
    e = '{0, 0, 0, 0, 0, 0, 0, 0, -1}; pending_mats.push_back(pack_matrix(e));
    e = '{-32768, 0, 0, 0, -32768, 0, 0, 0, -32768}; pending_mats.push_back(pack_matrix(e));
    e = '{-16384, 1, 1, 1, -16384, 1, 1, 1, -16383}; pending_mats.push_back(pack_matrix(e));
    e = '{-20000, 30000, 30000, 30000, -20000, 30000, 30000, 30000, -20000};
    pending_mats.push_back(pack_matrix(e));
    for (int i = 0; i < 1800; i++) begin
      if ($urandom_range(9) < 7) begin
        pending_mats.push_back(random_rotation($urandom_range(1)));
      end else begin
        for (int k = 0; k < 9; k++) e[k] = rand_entry($urandom_range(1));
        pending_mats.push_back(pack_matrix(e));
      end
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    while (pending_mats.size() >= 900) @(posedge clk);
    @(posedge clk);
    hold_sender <= 1'b1;
    @(posedge clk);
    while (expected_quats.size() != 0 || s_axis_tvalid) @(posedge clk);
    @(posedge clk);
    hold_sender <= 1'b0;
    while (pending_mats.size() != 0) @(posedge clk);
    while (s_axis_tvalid || expected_quats.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatches == 0 && expected_quats.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/r2q_pkg.sv
hw/rtl/r2q_front.sv
hw/rtl/r2q_sqrt.sv
hw/rtl/r2q_div.sv
hw/rtl/rotation_matrix_to_quaternion_core.sv
verif/rotation_matrix_to_quaternion_core_tb.sv
